// ===== hw/rtl/bto_pkg.sv =====
// shared types, codes and constants for the box table overlap query block
package bto_pkg;

  // table depth and register reset values
  localparam int DEFAULT_MAX_BOXES = 64;
  localparam logic [11:0] RAIL_W_RESET = 12'd384;
  localparam logic [11:0] RAIL_H_RESET = 12'd64;

  // doubled coordinate plus or minus a size fits in this many signed bits
  localparam int CMP_W = 27;

  // operation codes of an input item
  typedef enum logic [1:0] {
    FUNC_APPEND = 2'd0,
    FUNC_REMOVE = 2'd1,
    FUNC_CLEAR  = 2'd2,
    FUNC_QUERY  = 2'd3
  } func_t;

  // status codes of a result item
  typedef enum logic [1:0] {
    STAT_OK      = 2'd0,
    STAT_FULL    = 2'd1,
    STAT_NOMATCH = 2'd2
  } status_t;

  // configuration register indexes
  typedef enum logic {
    CFG_RAIL_W = 1'b0,
    CFG_RAIL_H = 1'b1
  } cfg_idx_t;

  // sequencer states
  typedef enum logic [1:0] {
    ST_IDLE  = 2'd0,
    ST_SCAN  = 2'd1,
    ST_SHIFT = 2'd2
  } state_t;

  // doubled probe edges, latched when an item is accepted
  typedef struct packed {
    logic signed [CMP_W-1:0] lo_x;
    logic signed [CMP_W-1:0] hi_x;
    logic signed [CMP_W-1:0] lo_y;
    logic signed [CMP_W-1:0] hi_y;
  } probe_t;

  // flags from the compare unit for the entry being examined
  typedef struct packed {
    logic equal;
    logic overlap;
  } cmp_res_t;

endpackage

// ===== hw/rtl/bto_store.sv =====
// box centre memory: one write port, one registered read port
module bto_store import bto_pkg::*; #(
  parameter int MAX_BOXES = DEFAULT_MAX_BOXES,
  parameter int AW = (MAX_BOXES > 1) ? $clog2(MAX_BOXES) : 1
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [AW-1:0]        waddr,
  input  logic signed [23:0]   wdata_x,
  input  logic signed [23:0]   wdata_y,
  input  logic [AW-1:0]        raddr,
  output logic signed [23:0]   rdata_x,
  output logic signed [23:0]   rdata_y
);

  logic [47:0] mem [MAX_BOXES];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= {wdata_x, wdata_y};
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata_x <= mem[raddr][47:24];
    rdata_y <= mem[raddr][23:0];
  end

endmodule

// ===== hw/rtl/bto_cmp.sv =====
// shared compare unit: exact match and strict overlap against one stored box
module bto_cmp import bto_pkg::*; (
  input  logic signed [23:0] box_x,
  input  logic signed [23:0] box_y,
  input  logic signed [23:0] key_x,
  input  logic signed [23:0] key_y,
  input  probe_t             probe,
  input  logic [11:0]        rail_w,
  input  logic [11:0]        rail_h,
  output cmp_res_t           res
);

  logic signed [CMP_W-1:0] bx2;
  logic signed [CMP_W-1:0] by2;
  logic signed [CMP_W-1:0] bw;
  logic signed [CMP_W-1:0] bh;
  logic signed [CMP_W-1:0] bx_hi;
  logic signed [CMP_W-1:0] bx_lo;
  logic signed [CMP_W-1:0] by_hi;
  logic signed [CMP_W-1:0] by_lo;

  // doubled box edges
  always_comb begin
    bx2   = CMP_W'(box_x) <<< 1;
    by2   = CMP_W'(box_y) <<< 1;
    bw    = signed'(CMP_W'(rail_w));
    bh    = signed'(CMP_W'(rail_h));
    bx_hi = bx2 + bw;
    bx_lo = bx2 - bw;
    by_hi = by2 + bh;
    by_lo = by2 - bh;
  end

  // strict overlap on both axes, exact centre match
  assign res.overlap = (probe.lo_x < bx_hi) && (probe.hi_x > bx_lo) &&
                       (probe.lo_y < by_hi) && (probe.hi_y > by_lo);
  assign res.equal   = (box_x == key_x) && (box_y == key_y);

endmodule

// ===== hw/rtl/bto_ctrl.sv =====
// sequencer: table count, scan and shift-down, result registers
module bto_ctrl import bto_pkg::*; #(
  parameter int MAX_BOXES = DEFAULT_MAX_BOXES,
  parameter int AW = (MAX_BOXES > 1) ? $clog2(MAX_BOXES) : 1,
  parameter int CW = $clog2(MAX_BOXES + 1)
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  logic [1:0]          func,
  input  logic signed [23:0]  pos_x,
  input  logic signed [23:0]  pos_y,
  input  logic [11:0]         probe_w,
  input  logic [11:0]         probe_h,
  input  logic [22:0]         scroll_offset,
  input  logic [11:0]         rail_w,
  input  logic [11:0]         rail_h,
  output logic                mem_we,
  output logic [AW-1:0]       mem_waddr,
  output logic signed [23:0]  mem_wx,
  output logic signed [23:0]  mem_wy,
  output logic [AW-1:0]       mem_raddr,
  input  logic signed [23:0]  mem_rx,
  input  logic signed [23:0]  mem_ry,
  output logic signed [23:0]  key_x,
  output logic signed [23:0]  key_y,
  output probe_t              probe,
  input  cmp_res_t            cmp_res,
  output logic                done,
  output logic [1:0]          status,
  output logic                hit,
  output logic signed [24:0]  hit_x,
  output logic signed [23:0]  hit_y,
  output logic [11:0]         hit_w,
  output logic [11:0]         hit_h
);

  state_t                 state;
  state_t                 state_next;
  func_t                  op;
  logic [AW-1:0]          idx;
  logic [AW-1:0]          idx_next;
  logic [AW-1:0]          idx_inc;
  logic [CW-1:0]          count;
  logic [CW-1:0]          count_next;
  logic [22:0]            scroll;
  logic                   last;
  logic                   full;
  logic                   finish;
  status_t                res_status;
  logic                   res_hit;
  logic signed [24:0]     diff_x;
  logic signed [CMP_W-1:0] px2;
  logic signed [CMP_W-1:0] py2;

  assign busy    = (state != ST_IDLE);
  assign idx_inc = idx + AW'(1);
  assign last    = ((CW'(idx) + CW'(1)) == count);
  assign full    = (count >= CW'(MAX_BOXES));
  assign diff_x  = 25'(mem_rx) - signed'(25'(scroll));

  // doubled probe centre from the input ports
  always_comb begin
    px2 = CMP_W'(pos_x) <<< 1;
    py2 = CMP_W'(pos_y) <<< 1;
  end

  // item latch
  always_ff @(posedge clk) begin
    if (start && !busy) begin
      op         <= func_t'(func);
      key_x      <= pos_x;
      key_y      <= pos_y;
      scroll     <= scroll_offset;
      probe.lo_x <= px2 - signed'(CMP_W'(probe_w));
      probe.hi_x <= px2 + signed'(CMP_W'(probe_w));
      probe.lo_y <= py2 - signed'(CMP_W'(probe_h));
      probe.hi_y <= py2 + signed'(CMP_W'(probe_h));
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      idx   <= '0;
      count <= '0;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      idx   <= idx_next;
      count <= count_next;
      done  <= finish;
    end
  end

  // result registers
  always_ff @(posedge clk) begin
    if (finish) begin
      status <= res_status;
      hit    <= res_hit;
      hit_x  <= res_hit ? diff_x : '0;
      hit_y  <= res_hit ? mem_ry : '0;
      hit_w  <= res_hit ? rail_w : '0;
      hit_h  <= res_hit ? rail_h : '0;
    end
  end

  // next state, memory port and result selection
  always_comb begin
    state_next = state;
    idx_next   = idx;
    count_next = count;
    finish     = 1'b0;
    res_status = STAT_OK;
    res_hit    = 1'b0;
    mem_we     = 1'b0;
    mem_waddr  = count[AW-1:0];
    mem_wx     = pos_x;
    mem_wy     = pos_y;
    mem_raddr  = idx_inc;
    unique case (state)
      ST_IDLE: begin
        mem_raddr = '0;
        if (start) begin
          unique case (func_t'(func)) inside
            FUNC_APPEND: begin
              finish = 1'b1;
              if (full) begin
                res_status = STAT_FULL;
              end else begin
                mem_we     = 1'b1;
                count_next = count + CW'(1);
              end
            end
            FUNC_CLEAR: begin
              finish     = 1'b1;
              count_next = '0;
            end
            FUNC_REMOVE, FUNC_QUERY: begin
              if (count == '0) begin
                finish = 1'b1;
                if (func_t'(func) == FUNC_REMOVE) begin
                  res_status = STAT_NOMATCH;
                end
              end else begin
                idx_next   = '0;
                state_next = ST_SCAN;
              end
            end
            default: begin
              finish = 1'b0;
            end
          endcase
        end
      end
      ST_SCAN: begin
        if (op == FUNC_QUERY) begin
          if (cmp_res.overlap) begin
            finish     = 1'b1;
            res_hit    = 1'b1;
            state_next = ST_IDLE;
          end else if (last) begin
            finish     = 1'b1;
            state_next = ST_IDLE;
          end else begin
            idx_next = idx_inc;
          end
        end else begin
          if (cmp_res.equal) begin
            if (last) begin
              finish     = 1'b1;
              count_next = count - CW'(1);
              state_next = ST_IDLE;
            end else begin
              idx_next   = idx_inc;
              state_next = ST_SHIFT;
            end
          end else if (last) begin
            finish     = 1'b1;
            res_status = STAT_NOMATCH;
            state_next = ST_IDLE;
          end else begin
            idx_next = idx_inc;
          end
        end
      end
      ST_SHIFT: begin
        // move entry idx down one place
        mem_we    = 1'b1;
        mem_waddr = idx - AW'(1);
        mem_wx    = mem_rx;
        mem_wy    = mem_ry;
        if (last) begin
          finish     = 1'b1;
          count_next = count - CW'(1);
          state_next = ST_IDLE;
        end else begin
          idx_next = idx_inc;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // count stays within the table depth
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(MAX_BOXES))
    else $error("box count above table depth");

  // while scanning or shifting the index points at a valid entry
  a_idx_valid: assert property (@(posedge clk) disable iff (rst)
    busy |-> (CW'(idx) < count))
    else $error("scan index beyond box count");

  // a hit is only reported for a query
  a_hit_query: assert property (@(posedge clk) disable iff (rst)
    (done && hit) |-> (op == FUNC_QUERY))
    else $error("hit reported for a non-query item");

  // leaving the scan always delivers a result
  a_fall_done: assert property (@(posedge clk) disable iff (rst)
    $fell(busy) |-> done)
    else $error("scan ended without a result");

  // a successful remove shortens the table by one
  a_remove_count: assert property (@(posedge clk) disable iff (rst)
    (done && (op == FUNC_REMOVE) && (status == STAT_OK)) |->
      (count == $past(count) - CW'(1)))
    else $error("remove did not shorten the table");

endmodule

// ===== hw/rtl/box_table_overlap_query.sv =====
// top level of the box table overlap query block
// An item is taken when start is high and busy is low. Append and clear finish at once:
// the result strobe done is high in the cycle after the item is taken. Remove and query
// walk the table one entry per cycle through the single read port of the box memory; a
// query stops at its first overlap or after the last entry. A remove stops at a match, or
// reports no match after the last entry; after a match it shifts any later entries down,
// one per cycle. On an empty table both finish at once. The result strobe done is high
// for a single cycle, the result ports hold the result until the next one, and the
// receiver cannot hold it off. A new item may be taken in the same cycle as a result.
// The configuration channel is always ready; write rail_width and rail_height only while
// the block is idle.
module box_table_overlap_query import bto_pkg::*; #(
  parameter int MAX_BOXES = DEFAULT_MAX_BOXES
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  logic [1:0]          func,
  input  logic signed [23:0]  pos_x,
  input  logic signed [23:0]  pos_y,
  input  logic [11:0]         probe_w,
  input  logic [11:0]         probe_h,
  input  logic [22:0]         scroll_offset,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic                cfg_index,
  input  logic [11:0]         cfg_data,
  output logic                done,
  output logic [1:0]          status,
  output logic                hit,
  output logic signed [24:0]  hit_x,
  output logic signed [23:0]  hit_y,
  output logic [11:0]         hit_w,
  output logic [11:0]         hit_h
);

  localparam int AW = (MAX_BOXES > 1) ? $clog2(MAX_BOXES) : 1;
  localparam int CW = $clog2(MAX_BOXES + 1);

  logic [11:0]        rail_w;
  logic [11:0]        rail_h;
  logic               mem_we;
  logic [AW-1:0]      mem_waddr;
  logic signed [23:0] mem_wx;
  logic signed [23:0] mem_wy;
  logic [AW-1:0]      mem_raddr;
  logic signed [23:0] mem_rx;
  logic signed [23:0] mem_ry;
  logic signed [23:0] key_x;
  logic signed [23:0] key_y;
  probe_t             probe;
  cmp_res_t           cmp_res;

  assign cfg_ready = 1'b1;

  // shared box size registers
  always_ff @(posedge clk) begin
    if (rst) begin
      rail_w <= RAIL_W_RESET;
      rail_h <= RAIL_H_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_RAIL_W: rail_w <= cfg_data;
        CFG_RAIL_H: rail_h <= cfg_data;
        default:    rail_w <= rail_w;
      endcase
    end
  end

  // box centre memory
  bto_store #(
    .MAX_BOXES (MAX_BOXES),
    .AW        (AW)
  ) u_store (
    .clk     (clk),
    .we      (mem_we),
    .waddr   (mem_waddr),
    .wdata_x (mem_wx),
    .wdata_y (mem_wy),
    .raddr   (mem_raddr),
    .rdata_x (mem_rx),
    .rdata_y (mem_ry)
  );

  // compare unit on the entry just read
  bto_cmp u_cmp (
    .box_x  (mem_rx),
    .box_y  (mem_ry),
    .key_x  (key_x),
    .key_y  (key_y),
    .probe  (probe),
    .rail_w (rail_w),
    .rail_h (rail_h),
    .res    (cmp_res)
  );

  // sequencer
  bto_ctrl #(
    .MAX_BOXES (MAX_BOXES),
    .AW        (AW),
    .CW        (CW)
  ) u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .func          (func),
    .pos_x         (pos_x),
    .pos_y         (pos_y),
    .probe_w       (probe_w),
    .probe_h       (probe_h),
    .scroll_offset (scroll_offset),
    .rail_w        (rail_w),
    .rail_h        (rail_h),
    .mem_we        (mem_we),
    .mem_waddr     (mem_waddr),
    .mem_wx        (mem_wx),
    .mem_wy        (mem_wy),
    .mem_raddr     (mem_raddr),
    .mem_rx        (mem_rx),
    .mem_ry        (mem_ry),
    .key_x         (key_x),
    .key_y         (key_y),
    .probe         (probe),
    .cmp_res       (cmp_res),
    .done          (done),
    .status        (status),
    .hit           (hit),
    .hit_x         (hit_x),
    .hit_y         (hit_y),
    .hit_w         (hit_w),
    .hit_h         (hit_h)
  );

endmodule

// ===== tb/tb.sv =====
// testbench for the box table overlap query block
`timescale 1ns / 100ps

module tb;
  import bto_pkg::*;

  localparam int TABLE_DEPTH = DEFAULT_MAX_BOXES;
  localparam int TAIL_CYCLES = DEFAULT_MAX_BOXES + 8;

  // one operation on the box table
  typedef struct {
    func_t              op;
    logic signed [23:0] x;
    logic signed [23:0] y;
    logic [11:0]        w;
    logic [11:0]        h;
    logic [22:0]        scroll;
  } box_item_t;

  // one answer of the block
  typedef struct {
    status_t            status;
    logic               hit;
    logic signed [24:0] hx;
    logic signed [23:0] hy;
    logic [11:0]        hw;
    logic [11:0]        hh;
  } box_answer_t;

  logic               clk;
  logic               rst;
  logic               start;
  logic               busy;
  logic [1:0]         func;
  logic signed [23:0] pos_x;
  logic signed [23:0] pos_y;
  logic [11:0]        probe_w;
  logic [11:0]        probe_h;
  logic [22:0]        scroll_offset;
  logic               cfg_valid;
  logic               cfg_ready;
  logic               cfg_index;
  logic [11:0]        cfg_data;
  logic               done;
  logic [1:0]         status;
  logic               hit;
  logic signed [24:0] hit_x;
  logic signed [23:0] hit_y;
  logic [11:0]        hit_w;
  logic [11:0]        hit_h;

  // shadow copy of the box table and the rail size
  logic signed [23:0] shadow_x[$];
  logic signed [23:0] shadow_y[$];
  logic [11:0]        rail_w;
  logic [11:0]        rail_h;

  // answers still owed by the block, oldest first
  box_answer_t        owed_answers[$];

  // cluster around which random boxes are placed
  longint             area_x;
  longint             area_y;

  int                 fail_count;
  int                 item_count;
  int                 hit_count;
  int                 full_count;
  int                 miss_count;

  box_table_overlap_query u_dut (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .func          (func),
    .pos_x         (pos_x),
    .pos_y         (pos_y),
    .probe_w       (probe_w),
    .probe_h       (probe_h),
    .scroll_offset (scroll_offset),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .done          (done),
    .status        (status),
    .hit           (hit),
    .hit_x         (hit_x),
    .hit_y         (hit_y),
    .hit_w         (hit_w),
    .hit_h         (hit_h)
  );

  // clock
  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  // run limit
  initial begin
    #2_000_000;
    $display("== FAIL ==");
    $finish;
  end

  // strict overlap on one axis, centres doubled against the sizes
  function automatic bit spans_overlap(longint p, longint ps, longint b, longint bs);
    return ((2 * p - ps) < (2 * b + bs)) && ((2 * p + ps) > (2 * b - bs));
  endfunction

  // apply one item to the shadow table and work out the answer
  function automatic box_answer_t apply_table_op(box_item_t it);
    box_answer_t a;
    longint      dx;
    a.status = STAT_OK;
    a.hit    = 1'b0;
    a.hx     = '0;
    a.hy     = '0;
    a.hw     = '0;
    a.hh     = '0;
    case (it.op)
      FUNC_APPEND: begin
        if (shadow_x.size() >= TABLE_DEPTH) begin
          a.status = STAT_FULL;
          full_count++;
        end else begin
          shadow_x = {shadow_x, it.x};
          shadow_y = {shadow_y, it.y};
        end
      end
      FUNC_REMOVE: begin
        a.status = STAT_NOMATCH;
        for (int i = 0; i < shadow_x.size(); i++) begin
          if (shadow_x[i] == it.x && shadow_y[i] == it.y) begin
            shadow_x.delete(i);
            shadow_y.delete(i);
            a.status = STAT_OK;
            break;
          end
        end
        if (a.status == STAT_NOMATCH) miss_count++;
      end
      FUNC_CLEAR: begin
        shadow_x.delete();
        shadow_y.delete();
      end
      default: begin
        for (int i = 0; i < shadow_x.size(); i++) begin
          if (spans_overlap(it.x, it.w, shadow_x[i], rail_w) &&
              spans_overlap(it.y, it.h, shadow_y[i], rail_h)) begin
            dx    = longint'(shadow_x[i]) - longint'(it.scroll);
            a.hit = 1'b1;
            a.hx  = dx[24:0];
            a.hy  = shadow_y[i];
            a.hw  = rail_w;
            a.hh  = rail_h;
            hit_count++;
            break;
          end
        end
      end
    endcase
    item_count++;
    return a;
  endfunction

  task automatic check_field(string name, logic signed [63:0] want, logic signed [63:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endtask

  // result checker: every strobe must match the oldest owed answer
  always @(posedge clk) begin
    box_answer_t want;
    if (!rst && done === 1'b1) begin
      if (owed_answers.size() == 0) begin
        $error("result strobe with no item outstanding");
        fail_count++;
      end else begin
        want = owed_answers.pop_front();
        check_field("status", want.status, status);
        check_field("hit", want.hit, hit);
        check_field("hit_x", want.hx, hit_x);
        check_field("hit_y", want.hy, hit_y);
        check_field("hit_w", want.hw, hit_w);
        check_field("hit_h", want.hh, hit_h);
      end
    end
  end

  // drive one item and hold it until the block takes it
  task automatic send_item(box_item_t it);
    box_answer_t ans;
    start         <= 1'b1;
    func          <= it.op;
    pos_x         <= it.x;
    pos_y         <= it.y;
    probe_w       <= it.w;
    probe_h       <= it.h;
    scroll_offset <= it.scroll;
    do @(posedge clk); while (busy !== 1'b0);
    ans          = apply_table_op(it);
    owed_answers = {owed_answers, ans};
  endtask

  task automatic send_op(func_t op, longint x, longint y, int w, int h, int s);
    box_item_t it;
    it.op     = op;
    it.x      = x[23:0];
    it.y      = y[23:0];
    it.w      = w[11:0];
    it.h      = h[11:0];
    it.scroll = s[22:0];
    send_item(it);
  endtask

  // random sender idle time
  task automatic sender_gap(int idle_pct);
    if ($urandom_range(1, 100) <= idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  // stop sending until every owed answer is in
  task automatic wait_all_answers();
    start <= 1'b0;
    do @(posedge clk); while (owed_answers.size() != 0);
    repeat (2) @(posedge clk);
  endtask

  task automatic write_rail(cfg_idx_t idx, logic [11:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    if (idx == CFG_RAIL_W) rail_w = val;
    else rail_h = val;
  endtask

  // reprogram the shared box size while the block is idle
  task automatic set_rails(logic [11:0] w, logic [11:0] h);
    wait_all_answers();
    write_rail(CFG_RAIL_W, w);
    write_rail(CFG_RAIL_H, h);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic signed [23:0] clamp24(longint v);
    if (v > 64'sd8388607) return 24'sh7FFFFF;
    if (v < -64'sd8388608) return 24'sh800000;
    return v[23:0];
  endfunction

  function automatic logic signed [23:0] jitter(longint base, int span);
    return clamp24(base + longint'($urandom_range(0, 2 * span)) - span);
  endfunction

  function automatic logic signed [23:0] any24();
    logic [31:0] r;
    r = $urandom;
    return r[23:0];
  endfunction

  // random item of a given operation; removes and queries are mostly aimed at stored boxes
  function automatic box_item_t random_item(func_t op);
    box_item_t it;
    int        idx;
    int        k;
    it.op     = op;
    it.w      = ($urandom_range(0, 1) == 0) ? 12'($urandom_range(0, 4095))
                                            : 12'($urandom_range(0, 64));
    it.h      = ($urandom_range(0, 1) == 0) ? 12'($urandom_range(0, 4095))
                                            : 12'($urandom_range(0, 64));
    it.scroll = ($urandom_range(0, 9) < 7) ? 23'($urandom_range(0, 23'h7FFFFF))
                                           : 23'($urandom_range(0, 2000));
    it.x      = jitter(area_x, 2048);
    it.y      = jitter(area_y, 2048);
    k         = $urandom_range(0, 9);
    idx       = (shadow_x.size() > 0) ? $urandom_range(0, shadow_x.size() - 1) : 0;
    case (op)
      FUNC_APPEND: begin
        if (k == 0) begin
          it.x = any24();
          it.y = any24();
        end else if (k < 3 && shadow_x.size() > 0) begin
          it.x = shadow_x[idx];
          it.y = shadow_y[idx];
        end
      end
      FUNC_REMOVE: begin
        if (k < 8 && shadow_x.size() > 0) begin
          it.x = shadow_x[idx];
          it.y = shadow_y[idx];
        end else if (k == 8) begin
          it.x = any24();
          it.y = any24();
        end
      end
      FUNC_QUERY: begin
        if (k < 7 && shadow_x.size() > 0) begin
          it.x = jitter(shadow_x[idx], (int'(rail_w) + int'(it.w)) / 2 + 3);
          it.y = jitter(shadow_y[idx], (int'(rail_h) + int'(it.h)) / 2 + 3);
        end else if (k == 7) begin
          it.x = any24();
          it.y = any24();
        end
      end
      default: ;
    endcase
    return it;
  endfunction

  // each operation, field extremes, strict edges, duplicates and middle removal
  task automatic test_basic_ops();
    send_op(FUNC_QUERY, 0, 0, 0, 0, 0);
    send_op(FUNC_REMOVE, 0, 0, 0, 0, 0);
    send_op(FUNC_CLEAR, 0, 0, 0, 0, 0);
    send_op(FUNC_APPEND, 0, 0, 0, 0, 0);
    send_op(FUNC_APPEND, -8388608, 8388607, 0, 0, 0);
    send_op(FUNC_APPEND, 8388607, -8388608, 0, 0, 0);
    send_op(FUNC_APPEND, 0, 0, 0, 0, 0);
    send_op(FUNC_QUERY, 0, 0, 0, 0, 8388607);
    // probe edge touching the box edge is not an overlap
    send_op(FUNC_QUERY, 192, 0, 0, 0, 0);
    send_op(FUNC_QUERY, 191, 31, 0, 0, 0);
    send_op(FUNC_QUERY, 8388607, -8388608, 4095, 4095, 0);
    send_op(FUNC_QUERY, -8388608, 8388607, 4095, 4095, 8388607);
    // first of two equal entries goes, the rest shift down
    send_op(FUNC_REMOVE, 0, 0, 0, 0, 0);
    send_op(FUNC_QUERY, 0, 0, 0, 0, 5);
    send_op(FUNC_REMOVE, 1, 0, 0, 0, 0);
    send_op(FUNC_REMOVE, 8388607, -8388608, 0, 0, 0);
    send_op(FUNC_QUERY, 8388607, -8388608, 4095, 4095, 0);
    send_op(FUNC_CLEAR, 0, 0, 0, 0, 0);
    send_op(FUNC_QUERY, 0, 0, 4095, 4095, 0);
  endtask

  // zero-sized and largest boxes
  task automatic test_size_extremes();
    set_rails(12'd0, 12'd0);
    send_op(FUNC_APPEND, 5, -5, 0, 0, 0);
    send_op(FUNC_QUERY, 5, -5, 0, 0, 0);
    send_op(FUNC_QUERY, 5, -5, 1, 1, 0);
    set_rails(12'd4095, 12'd4095);
    send_op(FUNC_QUERY, 2052, -5, 0, 0, 0);
    send_op(FUNC_REMOVE, 5, -5, 0, 0, 0);
    send_op(FUNC_APPEND, -1, -1, 4095, 4095, 8388607);
  endtask

  // clear, then append past the table depth
  task automatic test_fill_to_full(int idle_pct);
    send_op(FUNC_CLEAR, 0, 0, 0, 0, 0);
    sender_gap(idle_pct);
    repeat (TABLE_DEPTH + 3) begin
      send_item(random_item(FUNC_APPEND));
      sender_gap(idle_pct);
    end
  endtask

  // mixed random operations
  task automatic test_random_traffic(int count, int idle_pct);
    int    r;
    func_t op;
    repeat (count) begin
      r = $urandom_range(0, 99);
      if (r < 3) op = FUNC_CLEAR;
      else if (r < 30) op = FUNC_APPEND;
      else if (r < 52) op = FUNC_REMOVE;
      else op = FUNC_QUERY;
      send_item(random_item(op));
      sender_gap(idle_pct);
      if ($urandom_range(1, 100) <= 2) wait_all_answers();
    end
  endtask

  task automatic run_phase(int idle_pct, logic [11:0] w, logic [11:0] h, bit near_corner);
    set_rails(w, h);
    if (near_corner) begin
      area_x = 64'sd8388607 - 1500;
      area_y = -64'sd8388608 + 1500;
    end else begin
      area_x = longint'($urandom_range(0, 16000000)) - 8000000;
      area_y = longint'($urandom_range(0, 16000000)) - 8000000;
    end
    test_fill_to_full(idle_pct);
    test_random_traffic(140, idle_pct);
  endtask

  // test sequence
  initial begin
    fail_count    = 0;
    item_count    = 0;
    hit_count     = 0;
    full_count    = 0;
    miss_count    = 0;
    rail_w        = RAIL_W_RESET;
    rail_h        = RAIL_H_RESET;
    area_x        = 0;
    area_y        = 0;
    rst           <= 1'b1;
    start         <= 1'b0;
    func          <= FUNC_APPEND;
    pos_x         <= '0;
    pos_y         <= '0;
    probe_w       <= '0;
    probe_h       <= '0;
    scroll_offset <= '0;
    cfg_valid     <= 1'b0;
    cfg_index     <= CFG_RAIL_W;
    cfg_data      <= '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    test_basic_ops();
    test_size_extremes();
    run_phase(0, 12'($urandom_range(0, 4095)), 12'($urandom_range(0, 4095)), 1'b0);
    run_phase(70, RAIL_W_RESET, RAIL_H_RESET, 1'b0);
    run_phase(0, 12'($urandom_range(1, 600)), 12'($urandom_range(1, 600)), 1'b0);
    run_phase(31, 12'd4095, 12'($urandom_range(0, 4095)), 1'b1);

    wait_all_answers();
    repeat (TAIL_CYCLES) @(posedge clk);
    $display("ran %0d items: %0d query hits, %0d appends to a full table, %0d failed removes",
             item_count, hit_count, full_count, miss_count);
    $display("box sizes from zero to 4095, sender idle at 0, 31 and 70 percent");
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hw/rtl/bto_pkg.sv
hw/rtl/bto_store.sv
hw/rtl/bto_cmp.sv
hw/rtl/bto_ctrl.sv
hw/rtl/box_table_overlap_query.sv
tb/tb.sv
